// ----- hw/rtl/fqrd_pkg.sv -----
package fqrd_pkg;

  localparam int DEPTH  = 16;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DW     = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 3;
  localparam int REM_W  = 4;

  localparam logic signed [DW-1:0] EMPTY_DATA = -32'sd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 3'd0,
    CMD_DEQ    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_RMV    = 3'd4
  } fqrd_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_BADIDX   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } fqrd_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SEARCH,
    ST_SHIFT
  } fqrd_state_t;

  typedef struct packed {
    logic fin;
    logic go_read;
    logic go_search;
    logic go_shift;
  } fqrd_ctl_t;

endpackage

// ----- hw/rtl/fifo_queue_with_range_delete.sv -----
// Each command goes from IDLE to EXEC. Enqueue, unused codes, an empty dequeue or peek,
// and a remove-before that deletes nothing finish there; a dequeue or peek on a non-empty
// queue reads the head slot and finishes in READ; search walks in SEARCH to a match or the
// end; a deleting remove-before moves slots in SHIFT. The walk reads one slot per cycle.
// One command is in work at a time: in_stall stays high until its result is registered.
// Reset (rst_n low, synchronous) empties the queue; the slot memory is not cleared.
module fifo_queue_with_range_delete import fqrd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [DW-1:0]     in_value,
  input  logic [CW-1:0]            in_target_pos,
  input  logic [CW-1:0]            in_remove_count,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DW-1:0]     out_data,
  output logic [STAT_W-1:0]        out_status,
  output logic [CW-1:0]            out_match_pos,
  output logic [REM_W-1:0]         out_removed,
  output logic [CW-1:0]            out_occupancy
);

  fqrd_state_t state_r, state_nxt;
  fqrd_ctl_t   ctl;

  logic [CMD_W-1:0]     cmd_r;
  logic signed [DW-1:0] value_r;
  logic [CW-1:0]        tpos_r, kcnt_r;

  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt, cmp_idx_r, cmp_idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic [REM_W-1:0] nrem_r, nrem_nxt;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_rdata_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata;

  logic                 out_valid_r;
  logic signed [DW-1:0] out_data_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [CW-1:0]        out_mpos_r, out_occ_r;
  logic [REM_W-1:0]     out_rem_r;

  logic signed [DW-1:0] fin_data;
  logic [STAT_W-1:0]    fin_status;
  logic [CW-1:0]        fin_mpos, fin_occ;
  logic [REM_W-1:0]     fin_rem;

  logic          out_free;
  logic          match;
  logic [CW-1:0] tpos_m1, nrem_calc, count_less;

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_status    = out_status_r;
  assign out_match_pos = out_mpos_r;
  assign out_removed   = out_rem_r;
  assign out_occupancy = out_occ_r;

  assign out_free   = !out_valid_r || !out_stall;
  assign match      = cmp_vld_r && (mem_rdata_r == value_r);
  assign tpos_m1    = tpos_r - CW'(1);
  assign nrem_calc  = (kcnt_r < tpos_m1) ? kcnt_r : tpos_m1;
  assign count_less = count_r - CW'(nrem_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (ctl.fin)            state_nxt = ST_IDLE;
        else if (ctl.go_read)   state_nxt = ST_READ;
        else if (ctl.go_search) state_nxt = ST_SEARCH;
        else if (ctl.go_shift)  state_nxt = ST_SHIFT;
      end
      ST_READ, ST_SEARCH, ST_SHIFT: begin
        if (ctl.fin) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    nrem_nxt    = nrem_r;
    mem_we      = 1'b0;
    mem_waddr   = tail_r;
    mem_wdata   = value_r;
    mem_re      = 1'b0;
    mem_raddr   = head_r;
    fin_data    = '0;
    fin_status  = STAT_OK;
    fin_mpos    = '0;
    fin_rem     = '0;
    fin_occ     = count_r;
    case (state_r)
      ST_EXEC: begin
        case (cmd_r)
          CMD_ENQ: begin
            if (out_free) begin
              ctl.fin = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                fin_status = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                tail_nxt  = tail_r + AW'(1);
                count_nxt = count_r + CW'(1);
                fin_occ   = count_r + CW'(1);
              end
            end
          end
          CMD_DEQ, CMD_PEEK: begin
            if (count_r == '0) begin
              if (out_free) begin
                ctl.fin    = 1'b1;
                fin_data   = EMPTY_DATA;
                fin_status = STAT_EMPTY;
              end
            end else begin
              mem_re      = 1'b1;
              ctl.go_read = 1'b1;
            end
          end
          CMD_SEARCH: begin
            idx_nxt       = '0;
            cmp_vld_nxt   = 1'b0;
            ctl.go_search = 1'b1;
          end
          CMD_RMV: begin
            if (tpos_r < CW'(2) || tpos_r > count_r) begin
              if (out_free) begin
                ctl.fin    = 1'b1;
                fin_status = STAT_BADIDX;
              end
            end else if (nrem_calc == '0) begin
              ctl.fin = out_free;
            end else begin
              nrem_nxt     = REM_W'(nrem_calc);
              idx_nxt      = tpos_m1;
              cmp_vld_nxt  = 1'b0;
              ctl.go_shift = 1'b1;
            end
          end
          default: ctl.fin = out_free;
        endcase
      end
      ST_READ: begin
        if (out_free) begin
          ctl.fin  = 1'b1;
          fin_data = mem_rdata_r;
          if (cmd_r == CMD_DEQ) begin
            head_nxt  = head_r + AW'(1);
            count_nxt = count_r - CW'(1);
            fin_occ   = count_r - CW'(1);
          end
        end
      end
      ST_SEARCH: begin
        if (match || idx_r >= count_r) begin
          // Hold the last compare until the result register frees up.
          if (out_free) begin
            ctl.fin    = 1'b1;
            fin_status = match ? STAT_OK : STAT_NOTFOUND;
            fin_mpos   = match ? cmp_idx_r + CW'(1) : '0;
          end
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = head_r + idx_r[AW-1:0];
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r;
          idx_nxt     = idx_r + CW'(1);
        end
      end
      ST_SHIFT: begin
        // Slot read at offset i is written in the next cycle at offset i - nrem. Writes always
        // trail the reads, so no slot is overwritten before it has been read.
        cmp_vld_nxt = 1'b0;
        if (cmp_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = head_r + AW'(cmp_idx_r - CW'(nrem_r));
          mem_wdata = mem_rdata_r;
        end
        if (idx_r < count_r) begin
          mem_re      = 1'b1;
          mem_raddr   = head_r + idx_r[AW-1:0];
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r;
          idx_nxt     = idx_r + CW'(1);
        end else if (!cmp_vld_r && out_free) begin
          ctl.fin   = 1'b1;
          fin_rem   = nrem_r;
          count_nxt = count_less;
          tail_nxt  = head_r + count_less[AW-1:0];
          fin_occ   = count_less;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (ctl.fin) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    nrem_r    <= nrem_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
      tpos_r  <= in_target_pos;
      kcnt_r  <= in_remove_count;
    end
    if (ctl.fin) begin
      out_data_r   <= fin_data;
      out_status_r <= fin_status;
      out_mpos_r   <= fin_mpos;
      out_rem_r    <= fin_rem;
      out_occ_r    <= fin_occ;
    end
  end

endmodule

// ----- hw/rtl/fqrd_checker.sv -----
module fqrd_checker import fqrd_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [DW-1:0] out_data,
  input logic [STAT_W-1:0]    out_status,
  input logic [CW-1:0]        out_match_pos,
  input logic [REM_W-1:0]     out_removed,
  input logic [CW-1:0]        out_occupancy
);

  // An empty result always comes from an empty queue.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |-> out_data == EMPTY_DATA && out_occupancy == '0)
    else $error("empty status without an empty queue");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_occupancy == CW'(DEPTH))
    else $error("full status below capacity");

  // A rejected remove-before touches nothing.
  a_badidx_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_BADIDX |-> out_removed == '0 && out_match_pos == '0)
    else $error("bad index result reports work done");

  a_search_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_pos != '0 |-> out_match_pos <= out_occupancy)
    else $error("match position beyond occupancy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(out_status))
    else $error("stalled result transfer changed");

endmodule

bind fifo_queue_with_range_delete fqrd_checker u_fqrd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_data      (out_data),
  .out_status    (out_status),
  .out_match_pos (out_match_pos),
  .out_removed   (out_removed),
  .out_occupancy (out_occupancy)
);
